// ===== src/bpl_pkg.sv =====
package bpl_pkg;

  localparam int MAX_LIGHTS = 3;
  localparam int NUM_LIGHTS = 3;

  // configuration register indexes
  localparam logic [2:0] CFG_LIGHT_COUNT      = 3'd0;
  localparam logic [2:0] CFG_LIGHT0_POSITION  = 3'd1;
  localparam logic [2:0] CFG_LIGHT0_INTENSITY = 3'd2;
  localparam logic [2:0] CFG_LIGHT1_POSITION  = 3'd3;
  localparam logic [2:0] CFG_LIGHT1_INTENSITY = 3'd4;
  localparam logic [2:0] CFG_LIGHT2_POSITION  = 3'd5;
  localparam logic [2:0] CFG_LIGHT2_INTENSITY = 3'd6;

  localparam int ONE_Q14  = 16384;
  localparam int ONE_Q16  = 65536;
  localparam int AMB_Q16  = 3277;
  localparam int SPEC_EXP = 150;

  // unit vector block: sum of squares, sqrt, divide, sign
  localparam int U3_SQ_STEPS = 31;
  localparam int U3_DV_STEPS = 14;
  localparam int U3_LAT      = 1 + U3_SQ_STEPS + 1 + U3_DV_STEPS + 1;

  // saturating divider
  localparam int DIV_Q_BITS = 17;
  localparam int DIV_LAT    = 1 + DIV_Q_BITS;

  localparam int POW_STAGES = $clog2(SPEC_EXP + 1);

  // register stage of each step, counted from the input register
  localparam int ST_IN   = 1;
  localparam int ST_UIN  = ST_IN + 1;
  localparam int ST_U1   = ST_UIN + U3_LAT;
  localparam int ST_H    = ST_U1 + 1;
  localparam int ST_U2   = ST_H + U3_LAT;
  localparam int ST_X    = ST_U2 + 1;
  localparam int ST_SPEC = ST_X + POW_STAGES;
  localparam int ST_NUM  = ST_SPEC + 1;
  localparam int ST_DIV  = ST_NUM + DIV_LAT;
  localparam int ST_TERM = ST_DIV + 1;
  localparam int ST_OUT  = ST_TERM + 1;

  // clamped Q14 dot product of two unit vectors, negative gives zero
  function automatic logic [14:0] dot_pos(input logic signed [15:0] a [3],
                                          input logic signed [15:0] b [3]);
    logic signed [31:0] s;
    logic [17:0]        q;
    s = 32'(a[0]) * 32'(b[0]) + 32'(a[1]) * 32'(b[1]) + 32'(a[2]) * 32'(b[2]);
    q = s[31:14];
    if (s <= 0) begin
      return '0;
    end else if (q > 18'(ONE_Q14)) begin
      return 15'(ONE_Q14);
    end else begin
      return q[14:0];
    end
  endfunction

endpackage

// ===== src/bpl_if.sv =====
interface bpl_frag_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] pos_z;
  logic signed [15:0] nrm_x;
  logic signed [15:0] nrm_y;
  logic signed [15:0] nrm_z;
  logic [7:0]         base_r;
  logic [7:0]         base_g;
  logic [7:0]         base_b;

  modport source (output valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                  base_r, base_g, base_b, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, nrm_x, nrm_y, nrm_z,
                base_r, base_g, base_b, output ready);
endinterface

interface bpl_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_r;
  logic [7:0] out_g;
  logic [7:0] out_b;

  modport source (output valid, out_r, out_g, out_b, input ready);
  modport sink (input valid, out_r, out_g, out_b, output ready);
endinterface

// ===== src/blinn_phong_fragment_lighting.sv =====
// Throughput: one item per cycle; a stalled output holds the whole pipeline.
// Depth is set by two unit-vector blocks in series per light (31-stage sqrt
// plus 14-stage divide each) and the 17-stage saturating dividers.
// Reset: light_count 1, light registers 0, all pipeline valid bits cleared.
module blinn_phong_fragment_lighting (
  input  logic          clk_i,
  input  logic          rst_ni,
  bpl_frag_if.sink      frag_i,
  bpl_pix_if.source     pix_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [47:0]   cfg_wdata_i
);
  localparam int NL = bpl_pkg::NUM_LIGHTS;
  localparam int ML = bpl_pkg::MAX_LIGHTS;
  localparam int SI = bpl_pkg::ST_IN;
  localparam int S1 = bpl_pkg::ST_U1;
  localparam int S2 = bpl_pkg::ST_U2;
  localparam int SO = bpl_pkg::ST_OUT;
  localparam int SB = bpl_pkg::ST_SPEC - 1;

  logic [1:0]  cnt_q;
  logic [47:0] lpos_q [NL];
  logic [47:0] lint_q [NL];

  logic        vld_q [SI:SO];
  logic        en;

  logic signed [15:0] p_q [3];
  logic signed [15:0] nr_q [3];
  logic [7:0]         bs_q [SI:SB][3];
  logic signed [16:0] nr2_q [3];
  logic signed [16:0] v2_q [3];

  logic signed [15:0] nu [3];
  logic signed [15:0] vu [3];
  logic signed [15:0] nd_q [S1+1:S2][3];

  logic [17:0] term [ML][3];
  logic [19:0] acc [3];
  logic [16:0] clp [3];
  logic [23:0] scl [3];
  logic [7:0]  out_q [3];

  assign en = !vld_q[SO] || pix_o.ready;
  assign frag_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd1;
      for (int k = 0; k < NL; k++) begin
        lpos_q[k] <= '0;
        lint_q[k] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bpl_pkg::CFG_LIGHT_COUNT:      cnt_q     <= cfg_wdata_i[1:0];
        bpl_pkg::CFG_LIGHT0_POSITION:  lpos_q[0] <= cfg_wdata_i;
        bpl_pkg::CFG_LIGHT0_INTENSITY: lint_q[0] <= cfg_wdata_i;
        bpl_pkg::CFG_LIGHT1_POSITION:  lpos_q[1] <= cfg_wdata_i;
        bpl_pkg::CFG_LIGHT1_INTENSITY: lint_q[1] <= cfg_wdata_i;
        bpl_pkg::CFG_LIGHT2_POSITION:  lpos_q[2] <= cfg_wdata_i;
        bpl_pkg::CFG_LIGHT2_INTENSITY: lint_q[2] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = SI; s <= SO; s++) begin
        vld_q[s] <= 1'b0;
      end
    end else if (en) begin
      vld_q[SI] <= frag_i.valid;
      for (int s = SI + 1; s <= SO; s++) begin
        vld_q[s] <= vld_q[s-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0]  <= frag_i.pos_x;
      p_q[1]  <= frag_i.pos_y;
      p_q[2]  <= frag_i.pos_z;
      nr_q[0] <= frag_i.nrm_x;
      nr_q[1] <= frag_i.nrm_y;
      nr_q[2] <= frag_i.nrm_z;
      bs_q[SI][0] <= frag_i.base_r;
      bs_q[SI][1] <= frag_i.base_g;
      bs_q[SI][2] <= frag_i.base_b;
      for (int s = SI + 1; s <= SB; s++) begin
        bs_q[s] <= bs_q[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        nr2_q[i] <= 17'(nr_q[i]);
        // camera at the origin: view vector is minus the position
        v2_q[i]  <= -17'(p_q[i]);
      end
      nd_q[S1+1] <= nu;
      for (int s = S1 + 2; s <= S2; s++) begin
        nd_q[s] <= nd_q[s-1];
      end
      for (int i = 0; i < 3; i++) begin
        out_q[i] <= scl[i][23:16];
      end
    end
  end

  bpl_unit3 u_nrm (.clk_i(clk_i), .en_i(en), .c_i(nr2_q), .u_o(nu));
  bpl_unit3 u_view (.clk_i(clk_i), .en_i(en), .c_i(v2_q), .u_o(vu));

  for (genvar k = 0; k < ML; k++) begin : g_light
    bpl_light u_light (
      .clk_i  (clk_i),
      .en_i   (en),
      .lpos_i (lpos_q[k]),
      .lint_i (lint_q[k]),
      .p_i    (p_q),
      .vu_i   (vu),
      .n1_i   (nu),
      .n2_i   (nd_q[S2]),
      .base_i (bs_q[SB]),
      .term_o (term[k])
    );
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = '0;
      for (int k = 0; k < ML; k++) begin
        if (2'(k) < cnt_q) begin
          acc[i] = acc[i] + 20'(bpl_pkg::AMB_Q16) + 20'(term[k][i]);
        end
      end
      clp[i] = (acc[i] > 20'(bpl_pkg::ONE_Q16)) ? 17'(bpl_pkg::ONE_Q16) : acc[i][16:0];
      scl[i] = 24'(clp[i]) * 24'(255);
    end
  end

  assign pix_o.valid = vld_q[SO];
  assign pix_o.out_r = out_q[0];
  assign pix_o.out_g = out_q[1];
  assign pix_o.out_b = out_q[2];

endmodule

// ===== src/bpl_unit3.sv =====
module bpl_unit3 (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [16:0] c_i [3],
  output logic signed [15:0] u_o [3]
);
  localparam int SQ = bpl_pkg::U3_SQ_STEPS;
  localparam int DV = bpl_pkg::U3_DV_STEPS;

  // sqrt pipeline, two radicand bits per stage
  logic [61:0] sx_q [0:SQ];
  logic [30:0] rt_q [0:SQ];
  logic [33:0] rm_q [0:SQ];
  logic [16:0] mg_q [0:SQ][3];
  logic        ng_q [0:SQ][3];

  logic [35:0] rs [1:SQ];
  logic [35:0] tr [1:SQ];
  logic        sge [1:SQ];

  // divide pipeline, one quotient bit per stage
  logic [44:0] dr_q [0:DV][3];
  logic [13:0] dq_q [0:DV][3];
  logic        ds_q [0:DV][3];
  logic        dn_q [0:DV][3];
  logic [30:0] ln_q [0:DV];
  logic        lz_q [0:DV];

  logic [44:0] dsh [1:DV];
  logic        dge [1:DV][3];

  logic [16:0] mag [3];
  logic [33:0] ssum;

  logic signed [15:0] u_q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = c_i[i][16] ? 17'(-c_i[i]) : 17'(c_i[i]);
    end
    ssum = 34'(mag[0]) * 34'(mag[0]) + 34'(mag[1]) * 34'(mag[1])
         + 34'(mag[2]) * 34'(mag[2]);
  end

  always_comb begin
    for (int j = 1; j <= SQ; j++) begin
      rs[j]  = {rm_q[j-1], sx_q[j-1][61:60]};
      tr[j]  = {3'b000, rt_q[j-1], 2'b01};
      sge[j] = rs[j] >= tr[j];
    end
    for (int j = 1; j <= DV; j++) begin
      dsh[j] = 45'(ln_q[j-1]) << (DV - j);
      for (int i = 0; i < 3; i++) begin
        dge[j][i] = dr_q[j-1][i] >= dsh[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sx_q[0] <= {ssum, 28'b0};
      rt_q[0] <= '0;
      rm_q[0] <= '0;
      for (int i = 0; i < 3; i++) begin
        mg_q[0][i] <= mag[i];
        ng_q[0][i] <= c_i[i][16];
      end
      for (int j = 1; j <= SQ; j++) begin
        sx_q[j] <= {sx_q[j-1][59:0], 2'b00};
        rt_q[j] <= {rt_q[j-1][29:0], sge[j]};
        rm_q[j] <= sge[j] ? 34'(rs[j] - tr[j]) : rs[j][33:0];
        for (int i = 0; i < 3; i++) begin
          mg_q[j][i] <= mg_q[j-1][i];
          ng_q[j][i] <= ng_q[j-1][i];
        end
      end

      ln_q[0] <= rt_q[SQ];
      lz_q[0] <= rt_q[SQ] == '0;
      for (int i = 0; i < 3; i++) begin
        dr_q[0][i] <= {mg_q[SQ][i], 28'b0};
        dq_q[0][i] <= '0;
        ds_q[0][i] <= {mg_q[SQ][i], 28'b0} >= {rt_q[SQ], 14'b0};
        dn_q[0][i] <= ng_q[SQ][i];
      end
      for (int j = 1; j <= DV; j++) begin
        ln_q[j] <= ln_q[j-1];
        lz_q[j] <= lz_q[j-1];
        for (int i = 0; i < 3; i++) begin
          dr_q[j][i] <= dge[j][i] ? dr_q[j-1][i] - dsh[j] : dr_q[j-1][i];
          dq_q[j][i] <= {dq_q[j-1][i][12:0], dge[j][i]};
          ds_q[j][i] <= ds_q[j-1][i];
          dn_q[j][i] <= dn_q[j-1][i];
        end
      end

      for (int i = 0; i < 3; i++) begin
        if (lz_q[DV]) begin
          u_q[i] <= '0;
        end else if (ds_q[DV][i]) begin
          u_q[i] <= dn_q[DV][i] ? -16'(bpl_pkg::ONE_Q14) : 16'(bpl_pkg::ONE_Q14);
        end else begin
          u_q[i] <= dn_q[DV][i] ? -16'(dq_q[DV][i]) : 16'(dq_q[DV][i]);
        end
      end
    end
  end

  assign u_o = u_q;

endmodule

// ===== src/bpl_div.sv =====
module bpl_div (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [52:0] num_i,
  input  logic [41:0] den_i,
  output logic [16:0] q_o
);
  localparam int QB = bpl_pkg::DIV_Q_BITS;

  logic [52:0] rm_q [0:QB];
  logic [41:0] dn_q [0:QB];
  logic [16:0] qt_q [0:QB];
  logic        st_q [0:QB];

  logic [58:0] dsh [1:QB];
  logic        ge  [1:QB];

  always_comb begin
    for (int j = 1; j <= QB; j++) begin
      dsh[j] = 59'(dn_q[j-1]) << (QB - j);
      ge[j]  = 59'(rm_q[j-1]) >= dsh[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rm_q[0] <= num_i;
      dn_q[0] <= den_i;
      qt_q[0] <= '0;
      // quotient too big to matter: the channel clamps anyway
      st_q[0] <= 59'(num_i) >= {den_i, 17'b0};
      for (int j = 1; j <= QB; j++) begin
        rm_q[j] <= ge[j] ? 53'(59'(rm_q[j-1]) - dsh[j]) : rm_q[j-1];
        dn_q[j] <= dn_q[j-1];
        qt_q[j] <= {qt_q[j-1][15:0], ge[j]};
        st_q[j] <= st_q[j-1];
      end
    end
  end

  assign q_o = st_q[QB] ? '1 : qt_q[QB];

endmodule

// ===== src/bpl_light.sv =====
module bpl_light (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [47:0]        lpos_i,
  input  logic [47:0]        lint_i,
  input  logic signed [15:0] p_i [3],
  input  logic signed [15:0] vu_i [3],
  input  logic signed [15:0] n1_i [3],
  input  logic signed [15:0] n2_i [3],
  input  logic [7:0]         base_i [3],
  output logic [17:0]        term_o [3]
);
  localparam int SU = bpl_pkg::ST_UIN;
  localparam int SH = bpl_pkg::ST_H;
  localparam int SX = bpl_pkg::ST_X;
  localparam int SS = bpl_pkg::ST_SPEC;
  localparam int SD = bpl_pkg::ST_DIV;

  logic signed [16:0] d_q [3];
  logic [33:0]        r2_q [SU+1:SS];
  logic               zr_q [SU+1:SD];

  logic signed [15:0] lu [3];
  logic signed [16:0] h_q [3];
  logic [14:0]        ndl_q [SH:SS];
  logic signed [15:0] hu [3];

  logic [30:0] pb_q [SX:SS-1];
  logic [30:0] pr_q [SX:SS];

  logic [23:0] bi_q [3];
  logic [52:0] dnum_q [3];
  logic [52:0] snum_q [3];
  logic [41:0] dden_q;
  logic [41:0] sden_q;
  logic [16:0] qd [3];
  logic [16:0] qs [3];
  logic [17:0] term_q [3];

  logic [33:0] r2sum;

  assign r2sum = 34'(d_q[0]) * 34'(d_q[0]) + 34'(d_q[1]) * 34'(d_q[1])
               + 34'(d_q[2]) * 34'(d_q[2]);

  bpl_unit3 u_ld (.clk_i(clk_i), .en_i(en_i), .c_i(d_q), .u_o(lu));
  bpl_unit3 u_hv (.clk_i(clk_i), .en_i(en_i), .c_i(h_q), .u_o(hu));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        d_q[i] <= 17'($signed(lpos_i[16*i +: 16])) - 17'(p_i[i]);
        h_q[i] <= 17'(vu_i[i]) + 17'(lu[i]);
      end
      r2_q[SU+1] <= r2sum;
      zr_q[SU+1] <= r2sum == '0;
      for (int s = SU + 2; s <= SS; s++) begin
        r2_q[s] <= r2_q[s-1];
      end
      for (int s = SU + 2; s <= SD; s++) begin
        zr_q[s] <= zr_q[s-1];
      end

      ndl_q[SH] <= bpl_pkg::dot_pos(n1_i, lu);
      for (int s = SH + 1; s <= SS; s++) begin
        ndl_q[s] <= ndl_q[s-1];
      end

      pb_q[SX] <= {bpl_pkg::dot_pos(n2_i, hu), 16'b0};
      pr_q[SX] <= 31'(1) << 30;

      for (int i = 0; i < 3; i++) begin
        bi_q[i]   <= 24'(base_i[i]) * 24'(lint_i[16*i +: 16]);
        dnum_q[i] <= {39'(bi_q[i]) * 39'(ndl_q[SS]), 14'b0};
        snum_q[i] <= 53'(47'(lint_i[16*i +: 16]) * 47'(pr_q[SS]));
        term_q[i] <= zr_q[SD] ? '0 : 18'(qd[i]) + 18'(qs[i]);
      end
      dden_q <= 42'(r2_q[SS]) * 42'(255);
      sden_q <= 42'(r2_q[SS]) * 42'(5);
    end
  end

  // power by square and multiply, exponent bits from the bottom, Q30
  for (genvar s = SX + 1; s <= SS; s++) begin : g_pow
    logic [61:0] rp;
    logic [61:0] bp;
    assign bp = 62'(pb_q[s-1]) * 62'(pb_q[s-1]);
    if (((bpl_pkg::SPEC_EXP >> (s - SX - 1)) & 1) != 0) begin : g_mul
      assign rp = 62'(pr_q[s-1]) * 62'(pb_q[s-1]);
    end else begin : g_hold
      assign rp = {1'b0, pr_q[s-1], 30'b0};
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        pr_q[s] <= rp[60:30];
      end
    end
    if (s < SS) begin : g_sq
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          pb_q[s] <= bp[60:30];
        end
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_ch
    bpl_div u_ddiv (.clk_i(clk_i), .en_i(en_i), .num_i(dnum_q[i]), .den_i(dden_q),
                    .q_o(qd[i]));
    bpl_div u_sdiv (.clk_i(clk_i), .en_i(en_i), .num_i(snum_q[i]), .den_i(sden_q),
                    .q_o(qs[i]));
  end

  assign term_o = term_q;

endmodule
